// ===== hw/rtl/mersenne_twister_generator_unit_macros.svh =====
// Assertion macros for the MT19937 generator.
// Expect clk and rst_n in the scope of the module that uses them.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mtg_pkg.sv =====
// Package for the MT19937 generator: constants, types and the twist and
// tempering functions. No dependencies.
package mtg_pkg;

  localparam int MT_N   = 624;
  localparam int MT_M   = 397;
  localparam int ADDR_W = 10;
  localparam int POS_W  = 10;
  localparam int WORD_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MT_A = 32'h9908B0DF;
  localparam word_t MT_B = 32'h9D2C5680;
  localparam word_t MT_C = 32'hEFC60000;
  localparam word_t MT_F = 32'd1812433253;

  localparam pos_t POS_FULL     = POS_W'(MT_N);
  localparam pos_t POS_UNSEEDED = POS_W'(MT_N + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_EMIT
  } mtg_state_t;

  typedef enum logic [1:0] {
    SD_IDLE,
    SD_MUL,
    SD_ADD
  } mtg_sd_state_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } mtg_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mtg_seed_st_t;

  // Twist term from the top bit of word i and the low 31 bits of word i+1
  function automatic word_t mt_mix(input logic up, input logic [WORD_W-2:0] lo);
    word_t xa;
    xa = {1'b0, up, lo[WORD_W-2:1]};
    if (lo[0]) begin
      xa = xa ^ MT_A;
    end
    return xa;
  endfunction

  function automatic word_t mt_temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MT_B);
    y = y ^ ((y << 15) & MT_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hw/rtl/mtg_seeder.sv =====
// Seed sequencer: fills the state array with the 1812433253 recurrence, each
// word by a multiply then add, via a single registered multiplier. Uses mtg_pkg.
module mtg_seeder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mtg_pkg::word_t       seed,
  output mtg_pkg::mtg_wr_t     wr,
  output mtg_pkg::mtg_seed_st_t st
);
  import mtg_pkg::*;

  mtg_sd_state_t sst_r, sst_nxt;
  addr_t         idx_r, idx_nxt;
  word_t         word_r, word_nxt;
  word_t         prod_r, prod_nxt;
  word_t         sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sst_r <= SD_IDLE;
    end else begin
      sst_r <= sst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
    prod_r <= prod_nxt;
  end

  assign sum = prod_r + WORD_W'(idx_r);

  always_comb begin
    sst_nxt  = sst_r;
    idx_nxt  = idx_r;
    word_nxt = word_r;
    prod_nxt = prod_r;
    wr       = '0;
    st.busy  = (sst_r != SD_IDLE);
    st.done  = 1'b0;
    case (sst_r)
      SD_IDLE: begin
        if (start) begin
          wr.en    = 1'b1;
          wr.addr  = '0;
          wr.data  = seed;
          word_nxt = seed;
          idx_nxt  = ADDR_W'(1);
          sst_nxt  = SD_MUL;
        end
      end
      SD_MUL: begin
        prod_nxt = MT_F * (word_r ^ (word_r >> 30));
        sst_nxt  = SD_ADD;
      end
      SD_ADD: begin
        wr.en    = 1'b1;
        wr.addr  = idx_r;
        wr.data  = sum;
        word_nxt = sum;
        if (idx_r == ADDR_W'(MT_N - 1)) begin
          st.done = 1'b1;
          sst_nxt = SD_IDLE;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
          sst_nxt = SD_MUL;
        end
      end
      default: begin
        sst_nxt = SD_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mersenne_twister_generator_unit.sv =====
// MT19937 32-bit generator, top level: handshake, state memory, lazy twist
// and tempering. Uses mtg_pkg, mtg_seeder and the assertion macro header.
//
// A transfer with in_tuser = 0 reseeds from in_tdata and returns nothing. The
// next input transfer waits while the seeder writes the 624 state words:
// word 0 in the transfer cycle, then each further word by a multiply, then an
// add. A transfer with in_tuser = 1 returns one tempered word. The next input
// transfer waits until that word is in the output register. The request
// passes through three reads of the state memory through its one read port
// (words i, i+1 and i+397), followed by the write-back of the twisted word i.
// The twist is done one word per output, in order, so no full-array pass
// ever stalls the stream. Before the first seed a request returns 0 with
// out_tuser = 1, skipping the reads, and the next input transfer waits until
// that result is in the output register. The result sits in an output
// register, so the block takes the next item while a result waits.
// The following result is held, and the input with it, until that register
// has been taken.
`include "mersenne_twister_generator_unit_macros.svh"

module mersenne_twister_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic        in_tuser,   // [0] op: 0 reseed, 1 next word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic        out_tuser   // [0] status: 1 never seeded
);
  import mtg_pkg::*;

  mtg_state_t state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  logic       stat_r, stat_nxt;
  logic       a_r, a_nxt;
  logic [WORD_W-2:0] b_r, b_nxt;
  word_t      tw_r, tw_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_data_r, out_data_nxt;
  logic       out_user_r, out_user_nxt;

  word_t      mem [MT_N];
  word_t      rdata_r;
  addr_t      rd_addr;
  addr_t      q, q1, qm;
  logic [ADDR_W:0] qm_sum;

  mtg_wr_t      seed_wr, tw_wr, mem_wr;
  mtg_seed_st_t seed_st;
  logic         seed_start;
  logic         in_xfer;
  logic         out_load;
  word_t        twisted;

  mtg_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seed_start),
    .seed  (in_tdata),
    .wr    (seed_wr),
    .st    (seed_st)
  );

  // Addresses of the three taps for word q
  assign q      = addr_t'(pos_r);
  assign q1     = (q == ADDR_W'(MT_N - 1)) ? '0 : q + ADDR_W'(1);
  assign qm_sum = {1'b0, q} + (ADDR_W + 1)'(MT_M);
  assign qm     = (qm_sum >= (ADDR_W + 1)'(MT_N)) ?
                  addr_t'(qm_sum - (ADDR_W + 1)'(MT_N)) : addr_t'(qm_sum);

  assign twisted = rdata_r ^ mt_mix(a_r, b_r);
  assign mem_wr  = seed_wr.en ? seed_wr : tw_wr;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_UNSEEDED;
      stat_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    tw_r       <= tw_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign seed_start = in_xfer && !in_tuser;
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    stat_nxt      = stat_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    tw_nxt        = tw_r;
    tw_wr         = '0;
    rd_addr       = q;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!in_tuser) begin
            state_nxt = ST_SEED;
          end else if (pos_r > POS_FULL) begin
            stat_nxt  = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            stat_nxt = 1'b0;
            if (pos_r == POS_FULL) begin
              pos_nxt = '0;
            end
            state_nxt = ST_RD0;
          end
        end
      end
      ST_SEED: begin
        if (seed_st.done) begin
          pos_nxt   = POS_FULL;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD0: begin
        rd_addr   = q;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        rd_addr   = q1;
        a_nxt     = rdata_r[WORD_W-1];
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        rd_addr   = qm;
        b_nxt     = rdata_r[WORD_W-2:0];
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        tw_nxt     = twisted;
        tw_wr.en   = 1'b1;
        tw_wr.addr = q;
        tw_wr.data = twisted;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = stat_r;
          out_data_nxt  = stat_r ? '0 : mt_temper(tw_r);
          if (!stat_r) begin
            pos_nxt = pos_r + POS_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `MTG_ASSERT_SAME(a_unseeded_zero, out_tvalid && out_tuser, out_tdata == '0, "unseeded result not zero")
  `MTG_ASSERT_SAME(a_seed_busy, state_r == ST_SEED, seed_st.busy, "seed wait without seeder running")
  `MTG_ASSERT_SAME(a_wr_range, mem_wr.en, mem_wr.addr < ADDR_W'(MT_N), "state write out of range")
  `MTG_ASSERT_NEXT(a_seed_pos, seed_st.done, pos_r == POS_FULL, "position not full after seeding")

endmodule

// ===== tb/mersenne_twister_generator_unit_checker.sv =====
// MT19937 generator checker: watches both stream channels, predicts every
// tempered word from its own copy of the state array and compares results.
// Depends on mtg_pkg for the generator constants; defines mtg_tb_pkg.
`timescale 1ns / 1ps

package mtg_tb_pkg;

  typedef enum logic {
    OP_RESEED = 1'b0,
    OP_NEXT   = 1'b1
  } mtg_op_t;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_UNSEEDED = 1'b1
  } mtg_status_t;

endpackage

module mersenne_twister_generator_unit_checker
  import mtg_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic        in_tuser,   // [0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] value
  input  logic        out_tuser,  // [0] status
  output int          mismatch_count,
  output int          results_owed
);

  typedef struct packed {
    logic [31:0] value;
    mtg_status_t status;
  } mt_result_t;

  localparam int          WORDS      = mtg_pkg::MT_N;
  localparam int          MIDDLE     = mtg_pkg::MT_M;
  localparam int unsigned NOT_SEEDED = WORDS + 1;

  logic [31:0] mt_words [WORDS];
  int unsigned mt_pos = NOT_SEEDED;
  mt_result_t  owed_words [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  function automatic void load_seed(input logic [31:0] s);
    int          i;
    logic [31:0] p;
    mt_words[0] = s;
    for (i = 1; i < WORDS; i++) begin
      p = mt_words[i-1];
      mt_words[i] = 32'(mtg_pkg::MT_F * (p ^ (p >> 30)) + 32'(i));
    end
    mt_pos = WORDS;
  endfunction

  // In-place regeneration: later words see the already twisted early ones
  function automatic void twist_words();
    int          i;
    logic [31:0] x;
    logic [31:0] xa;
    for (i = 0; i < WORDS; i++) begin
      x  = {mt_words[i][31], mt_words[(i + 1) % WORDS][30:0]};
      xa = x >> 1;
      if (x[0]) begin
        xa = xa ^ mtg_pkg::MT_A;
      end
      mt_words[i] = mt_words[(i + MIDDLE) % WORDS] ^ xa;
    end
    mt_pos = 0;
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::MT_B);
    y = y ^ ((y << 15) & mtg_pkg::MT_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic mt_result_t next_word();
    mt_result_t r;
    r.value  = '0;
    r.status = STATUS_UNSEEDED;
    if (mt_pos <= WORDS) begin
      if (mt_pos == WORDS) begin
        twist_words();
      end
      r.value  = temper_word(mt_words[mt_pos]);
      r.status = STATUS_OK;
      mt_pos++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mt_result_t want;
    if (!rst_n) begin
      mt_pos = NOT_SEEDED;
      owed_words.delete();
    end else begin
      // compare before predicting: a word accepted now cannot be this edge's result
      if (out_tvalid && out_tready) begin
        if (owed_words.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result value %h status %0d", $time,
                     out_tdata, out_tuser);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = owed_words.pop_front();
          if (out_tdata !== want.value || out_tuser !== want.status) begin
            if (mismatch_count < 10) begin
              $display("%0t: value exp %h got %h, status exp %0d got %0d", $time,
                       want.value, out_tdata, want.status, out_tuser);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_RESEED) begin
          load_seed(in_tdata);
        end else begin
          owed_words.push_back(next_word());
        end
      end
    end
    results_owed <= owed_words.size();
  end

endmodule

// ===== tb/mersenne_twister_generator_unit_test.sv =====
// Testbench top for the MT19937 generator: clock, reset, stimulus and verdict.
// Depends on mersenne_twister_generator_unit and the checker (mtg_tb_pkg).
`timescale 1ns / 1ps

module mersenne_twister_generator_unit_test;
  import mtg_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 1300;  // covers a reseed still running

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  int          mismatch_count;
  int          results_owed;
  int          cycle_count = 0;
  bit          steady_run  = 1'b0;

  mersenne_twister_generator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mersenne_twister_generator_unit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= steady_run || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mersenne_twister_generator_unit_test failed");
      $finish;
    end
  end

  // Entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_item(input mtg_op_t op, input logic [31:0] seed);
    while (!steady_run && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    int k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_NEXT;
    in_tdata  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // requests before any seed
    send_item(OP_NEXT, 32'h0000_0000);
    send_item(OP_NEXT, 32'hFFFF_FFFF);
    send_item(OP_RESEED, 32'h0000_0000);
    repeat (3) send_item(OP_NEXT, $urandom());
    send_item(OP_RESEED, 32'hFFFF_FFFF);
    repeat (2) send_item(OP_NEXT, $urandom());

    // hold off until every result is back
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);

    send_item(OP_RESEED, 32'd5489);
    repeat (2) send_item(OP_NEXT, $urandom());
    send_item(OP_RESEED, 32'h8000_0000);
    send_item(OP_NEXT, 32'h0000_0000);
    // reseed straight over a reseed
    send_item(OP_RESEED, 32'h0000_0001);
    send_item(OP_RESEED, $urandom());
    send_item(OP_NEXT, 32'hFFFF_FFFF);
    send_item(OP_NEXT, $urandom());

    // long run: crosses the second twist of the array
    send_item(OP_RESEED, $urandom());
    for (k = 0; k < 700; k++) begin
      steady_run = (k >= 100 && k < 400);
      send_item(OP_NEXT, $urandom());
    end
    steady_run = 1'b0;

    // short runs broken by reseeds
    for (k = 0; k < 60; k++) begin
      send_item(mtg_op_t'($urandom_range(0, 99) >= 30), $urandom());
    end

    in_tvalid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("mersenne_twister_generator_unit_test passed");
    end else begin
      $display("mersenne_twister_generator_unit_test failed");
    end
    $finish;
  end

endmodule
